[rtl/core/lru_prepared_operand_directory_core_assert.svh]
// Assertion macros used by the prepared-operand directory core.
`ifndef LRU_PREPARED_OPERAND_DIRECTORY_CORE_ASSERT_SVH
`define LRU_PREPARED_OPERAND_DIRECTORY_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define LPOD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LPOD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lpod_pkg.sv]
// Types and constants shared by the prepared-operand directory modules.
`timescale 1ns / 1ps

package lpod_pkg;

  localparam int OP_W       = 2;
  localparam int STAMP_W    = 64;
  localparam int SLOT_OUT_W = 5;
  localparam int RCNT_W     = 17;
  localparam int ACT_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREPARE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 4'd1;

  // Broadcast command from the controller to every slot cell.
  typedef struct packed {
    logic inv_en;
    logic wr_en;
    logic wr_set_tag;
    logic clr_all;
  } cell_cmd_t;

  // Control part of the victim-search token that walks along the cell chain.
  typedef struct packed {
    logic vld;
    logic found_empty;
    logic have;
  } scan_ctl_t;

endpackage

[rtl/core/lpod_cell.sv]
// One directory slot: used flag, tag, stamp and one stage of the victim search chain.
`timescale 1ns / 1ps

module lpod_cell #(
  parameter int SLOT_BITS = 5,
  parameter int TAG_W     = 16,
  parameter int IDX       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpod_pkg::cell_cmd_t           cmd,
  input  logic                          act,
  input  logic [TAG_W-1:0]              inv_tag,
  input  logic [TAG_W-1:0]              look_tag,
  input  logic [SLOT_BITS-1:0]          wr_idx,
  input  logic [TAG_W-1:0]              wr_tag,
  input  logic [lpod_pkg::STAMP_W-1:0]  wr_stamp,
  output logic                          match,
  input  lpod_pkg::scan_ctl_t           tok_ctl_in,
  input  logic [SLOT_BITS-1:0]          tok_idx_in,
  input  logic [lpod_pkg::STAMP_W-1:0]  tok_stamp_in,
  output lpod_pkg::scan_ctl_t           tok_ctl_out,
  output logic [SLOT_BITS-1:0]          tok_idx_out,
  output logic [lpod_pkg::STAMP_W-1:0]  tok_stamp_out
);
  import lpod_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_IDX = SLOT_BITS'(IDX);

  logic                 used_r, used_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [STAMP_W-1:0]   stamp_r, stamp_nxt;
  scan_ctl_t            tctl_r, tctl_nxt;
  logic [SLOT_BITS-1:0] tidx_r, tidx_nxt;
  logic [STAMP_W-1:0]   tstamp_r, tstamp_nxt;
  logic                 inv_hit;
  logic                 sel;

  assign match   = used_r && act && (tag_r == look_tag);
  assign inv_hit = cmd.inv_en && used_r && act && (tag_r == inv_tag);
  assign sel     = cmd.wr_en && (wr_idx == MY_IDX);

  always_comb begin
    used_nxt  = used_r;
    tag_nxt   = tag_r;
    stamp_nxt = stamp_r;
    if (cmd.clr_all) begin
      used_nxt = 1'b0;
    end else if (sel && cmd.wr_set_tag) begin
      used_nxt = 1'b1;
    end else if (inv_hit) begin
      used_nxt = 1'b0;
    end
    if (sel && cmd.wr_set_tag) begin
      tag_nxt = wr_tag;
    end
    if (sel) begin
      stamp_nxt = wr_stamp;
    end
  end

  // The first empty slot wins outright; otherwise the least stamp, earliest slot on a tie.
  always_comb begin
    tctl_nxt   = tok_ctl_in;
    tidx_nxt   = tok_idx_in;
    tstamp_nxt = tok_stamp_in;
    if (tok_ctl_in.vld && act && !tok_ctl_in.found_empty) begin
      if (!used_r) begin
        tctl_nxt.found_empty = 1'b1;
        tctl_nxt.have        = 1'b1;
        tidx_nxt             = MY_IDX;
      end else if (!tok_ctl_in.have || (stamp_r < tok_stamp_in)) begin
        tctl_nxt.have = 1'b1;
        tidx_nxt      = MY_IDX;
        tstamp_nxt    = stamp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tctl_r <= '0;
    end else begin
      used_r <= used_nxt;
      tctl_r <= tctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r    <= tag_nxt;
    stamp_r  <= stamp_nxt;
    tidx_r   <= tidx_nxt;
    tstamp_r <= tstamp_nxt;
  end

  assign tok_ctl_out   = tctl_r;
  assign tok_idx_out   = tidx_r;
  assign tok_stamp_out = tstamp_r;

endmodule

[rtl/core/lru_prepared_operand_directory_core.sv]
// Top level of the fully associative prepared-operand directory with LRU replacement.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall       | operation, dst_reg, src_reg
//  out_    | output    | out_valid / out_stall     | hit, slot_valid, slot_index, status
//  cfg_    | input     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A write, a multiply, a prepare that hits or finds no active slot, and an erroneous or
//  unused operation go from one accepted word to the next through accept, execute and
//  load the output. A prepare that allocates adds a scan step that lasts until the
//  search token has walked along the row of slot cells at one cell per cycle.
//  Reset (rst_n, synchronous, active low) empties every slot and clears the use clock;
//  there is no clearing pass. A stalled output word holds the block in its last step
//  until the word is taken; a new input word is taken only once the previous result
//  has been handed to the output register.

module lru_prepared_operand_directory_core #(
  parameter int MAX_SLOTS      = 32,
  parameter int REG_INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lpod_pkg::OP_W-1:0]         in_operation,
  input  logic [REG_INDEX_BITS-1:0]         in_dst_reg,
  input  logic [REG_INDEX_BITS-1:0]         in_src_reg,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic                              out_slot_valid,
  output logic [lpod_pkg::SLOT_OUT_W-1:0]   out_slot_index,
  output logic                              out_status,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpod_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpod_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpod_pkg::*;

`include "lru_prepared_operand_directory_core_assert.svh"

  localparam int SLOT_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CMP_W     = (REG_INDEX_BITS > RCNT_W) ? REG_INDEX_BITS : RCNT_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [RCNT_W-1:0]         reg_count_r;
  logic [ACT_W-1:0]          active_r;
  logic [STAMP_W-1:0]        clock_r, clock_nxt;
  logic                      scan_go_r, scan_go_nxt;

  // Operation held while it is being worked on.
  logic [OP_W-1:0]           op_q;
  logic [REG_INDEX_BITS-1:0] dst_q;
  logic [REG_INDEX_BITS-1:0] src_q;

  // Result waiting to be loaded into the output register.
  logic                      res_hit_r, res_hit_nxt;
  logic                      res_sv_r, res_sv_nxt;
  logic [SLOT_BITS-1:0]      res_idx_r, res_idx_nxt;
  logic                      res_status_r, res_status_nxt;

  logic                      out_valid_r;
  logic                      out_hit_r;
  logic                      out_sv_r;
  logic [SLOT_OUT_W-1:0]     out_idx_r;
  logic                      out_status_r;

  cell_cmd_t                 cmd;
  logic [REG_INDEX_BITS-1:0] look_tag;
  logic [SLOT_BITS-1:0]      wr_idx;
  logic [STAMP_W-1:0]        stamp_new;
  logic [MAX_SLOTS-1:0]      match_vec;
  logic [MAX_SLOTS-1:0]      slot_act;
  logic                      any_match;
  logic [SLOT_BITS-1:0]      hit_idx;
  logic                      err;
  logic                      no_slots;
  logic                      in_accept;
  logic                      cfg_we;
  logic                      out_load;

  scan_ctl_t                 tok_ctl   [0:MAX_SLOTS];
  logic [SLOT_BITS-1:0]      tok_idx   [0:MAX_SLOTS];
  logic [STAMP_W-1:0]        tok_stamp [0:MAX_SLOTS];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign no_slots  = (active_r == '0);
  assign stamp_new = clock_r + STAMP_W'(1);

  // A multiply looks up its source; a prepare looks up its destination.
  assign look_tag = (op_q == OP_MULTIPLY) ? src_q : dst_q;

  // Write checks the destination only; prepare and multiply check both indices.
  always_comb begin
    err = 1'b0;
    if (op_q == OP_WRITE) begin
      err = CMP_W'(dst_q) >= CMP_W'(reg_count_r);
    end else if (op_q == OP_PREPARE || op_q == OP_MULTIPLY) begin
      err = (CMP_W'(dst_q) >= CMP_W'(reg_count_r)) ||
            (CMP_W'(src_q) >= CMP_W'(reg_count_r));
    end
  end

  // Tags are unique among used slots, so this only picks the one matching cell.
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = SLOT_BITS'(i);
      end
    end
  end
  assign any_match = |match_vec;

  // The search token enters the chain in the cycle after execution, so it sees the
  // slots as left by any invalidation of the same operation.
  assign tok_ctl[0]   = '{vld: scan_go_r, found_empty: 1'b0, have: 1'b0};
  assign tok_idx[0]   = '0;
  assign tok_stamp[0] = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    // Slots at or above the active count take part in nothing.
    assign slot_act[g] = (7'(g) < {1'b0, active_r});

    lpod_cell #(
      .SLOT_BITS (SLOT_BITS),
      .TAG_W     (REG_INDEX_BITS),
      .IDX       (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd),
      .act           (slot_act[g]),
      .inv_tag       (dst_q),
      .look_tag      (look_tag),
      .wr_idx        (wr_idx),
      .wr_tag        (dst_q),
      .wr_stamp      (stamp_new),
      .match         (match_vec[g]),
      .tok_ctl_in    (tok_ctl[g]),
      .tok_idx_in    (tok_idx[g]),
      .tok_stamp_in  (tok_stamp[g]),
      .tok_ctl_out   (tok_ctl[g+1]),
      .tok_idx_out   (tok_idx[g+1]),
      .tok_stamp_out (tok_stamp[g+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    clock_nxt      = clock_r;
    scan_go_nxt    = 1'b0;
    res_hit_nxt    = res_hit_r;
    res_sv_nxt     = res_sv_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    cmd            = '0;
    wr_idx         = hit_idx;
    out_load       = 1'b0;

    // Changing the active slot count empties the whole directory.
    cmd.clr_all = cfg_we && (cfg_index == CFG_ACTIVE_SLOTS);

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_hit_nxt    = 1'b0;
        res_sv_nxt     = 1'b0;
        res_idx_nxt    = '0;
        res_status_nxt = 1'b0;
        state_nxt      = S_RESP;
        if (err) begin
          res_status_nxt = 1'b1;
        end else begin
          case (op_q)
            OP_WRITE: begin
              cmd.inv_en = 1'b1;
            end
            OP_PREPARE: begin
              cmd.inv_en = (dst_q != src_q);
              if (no_slots) begin
                res_sv_nxt = 1'b0;
              end else if ((dst_q == src_q) && any_match) begin
                cmd.wr_en   = 1'b1;
                clock_nxt   = stamp_new;
                res_hit_nxt = 1'b1;
                res_sv_nxt  = 1'b1;
                res_idx_nxt = hit_idx;
              end else begin
                scan_go_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            OP_MULTIPLY: begin
              // Touch the source slot first; the destination may then empty it.
              cmd.inv_en = 1'b1;
              if (any_match) begin
                cmd.wr_en   = 1'b1;
                clock_nxt   = stamp_new;
                res_hit_nxt = 1'b1;
                res_sv_nxt  = 1'b1;
                res_idx_nxt = hit_idx;
              end
            end
            default: begin
              res_sv_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_ctl[MAX_SLOTS].vld) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_set_tag = 1'b1;
          wr_idx         = tok_idx[MAX_SLOTS];
          clock_nxt      = stamp_new;
          res_hit_nxt    = 1'b0;
          res_sv_nxt     = 1'b1;
          res_idx_nxt    = tok_idx[MAX_SLOTS];
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      scan_go_r   <= 1'b0;
      reg_count_r <= RCNT_W'(16);
      active_r    <= ACT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clock_r   <= clock_nxt;
      scan_go_r <= scan_go_nxt;
      if (cfg_we && (cfg_index == CFG_REG_COUNT)) begin
        reg_count_r <= cfg_data[RCNT_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_ACTIVE_SLOTS)) begin
        active_r <= cfg_data[ACT_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q  <= in_operation;
      dst_q <= in_dst_reg;
      src_q <= in_src_reg;
    end
    res_hit_r    <= res_hit_nxt;
    res_sv_r     <= res_sv_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_hit_r    <= res_hit_r;
      out_sv_r     <= res_sv_r;
      out_idx_r    <= SLOT_OUT_W'(res_idx_r);
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot_valid = out_sv_r;
  assign out_slot_index = out_idx_r;
  assign out_status     = out_status_r;

  `LPOD_ASSERT_IMP(a_lookup_unique, clk, rst_n, state_r == S_EXEC, $countones(match_vec) <= 1, "more than one used slot holds the looked-up tag")
  `LPOD_ASSERT_IMP(a_tail_in_scan, clk, rst_n, tok_ctl[MAX_SLOTS].vld, (state_r == S_SCAN) && tok_ctl[MAX_SLOTS].have, "search token left the chain outside a scan or without a victim")
  `LPOD_ASSERT_NXT(a_accept_exec, clk, rst_n, in_accept, state_r == S_EXEC, "accepted word was not executed in the next cycle")
  `LPOD_ASSERT_NXT(a_clock_quiet, clk, rst_n, (state_r != S_EXEC) && (state_r != S_SCAN), clock_r == $past(clock_r), "use clock moved outside execution or scan")

endmodule

[tb/sv/tb_lru_prepared_operand_directory_core.sv]
// Self-checking testbench for the LRU prepared-operand directory core.
`timescale 1ns / 1ps
module tb_lru_prepared_operand_directory_core;
  import lpod_pkg::*;

  localparam int MAX_SLOTS     = 32;
  localparam int REG_BITS      = 16;
  // Longest gap between two accepted words that a healthy run can show: an allocating
  // prepare behind a long output stall and a sender gap, with a wide margin on top.
  localparam int IDLE_LIMIT    = 4000;
  // Cycles allowed after the last result before the block is treated as quiet.
  localparam int SETTLE_CYCLES = MAX_SLOTS + 8;
  localparam int PHASE_WORDS   = 128;
  localparam int NUM_SETTINGS  = 7;
  localparam int NUM_DIRECTED  = 22;

  // Operation code 3 has no name in the package; the block treats it as a no-operation.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                  hit;
    logic                  slot_valid;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  status;
  } dir_result_t;

  // One row of the directed table. Where typed is set, the result word is written in by
  // hand; otherwise the directory predictor supplies it.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [REG_BITS-1:0] dst;
    logic [REG_BITS-1:0] src;
    bit                  typed;
    dir_result_t         res;
  } stim_row_t;

  localparam dir_result_t RES_EMPTY = '0;
  localparam dir_result_t RES_RANGE = '{hit: 1'b0, slot_valid: 1'b0, slot_index: '0,
                                        status: 1'b1};
  localparam dir_result_t RES_FIRST = '{hit: 1'b0, slot_valid: 1'b1, slot_index: '0,
                                        status: 1'b0};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation;
  logic [REG_BITS-1:0]   in_dst_reg;
  logic [REG_BITS-1:0]   in_src_reg;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_hit;
  logic                  out_slot_valid;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic                  out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lru_prepared_operand_directory_core #(
    .MAX_SLOTS      (MAX_SLOTS),
    .REG_INDEX_BITS (REG_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_dst_reg     (in_dst_reg),
    .in_src_reg     (in_src_reg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_slot_valid (out_slot_valid),
    .out_slot_index (out_slot_index),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------------
  // Shadow copy of the directory. It is advanced in the order in which words are
  // accepted, so the queue of pending results always matches the block's output order.
  // ---------------------------------------------------------------------------------
  bit                 dir_used  [MAX_SLOTS];
  logic [REG_BITS-1:0] dir_tag  [MAX_SLOTS];
  logic [63:0]        dir_stamp [MAX_SLOTS];
  logic [63:0]        use_clock;
  logic [RCNT_W-1:0]  reg_count;
  logic [ACT_W-1:0]   active_slots;

  dir_result_t        pending_results [$];

  // Bookkeeping for the end-of-run summary.
  int fail_count;
  int words_sent;
  int write_count;
  int prepare_count;
  int multiply_count;
  int unused_count;
  int hit_count;
  int range_error_count;
  int eviction_count;
  int setting_count;

  // Sender pacing state and the last prepared register, which multiplies often reuse.
  int                  burst_left;
  logic [REG_BITS-1:0] last_prepared;

  logic [RCNT_W-1:0]  phase_reg_count [NUM_SETTINGS] =
    '{17'd65536, 17'd1, 17'd40, 17'd65536, 17'd300, 17'd24, 17'd65536};
  logic [ACT_W-1:0]   phase_active    [NUM_SETTINGS] =
    '{6'd32, 6'd1, 6'd8, 6'd0, 6'd63, 6'd3, 6'd17};

  stim_row_t directed_rows [NUM_DIRECTED];

  // The active count saturates at the number of slots that exist.
  function automatic int live_slots();
    return (active_slots > MAX_SLOTS) ? MAX_SLOTS : int'(active_slots);
  endfunction

  // Finds the first used slot holding tag; a hit optionally takes a fresh stamp.
  function automatic int find_slot(logic [REG_BITS-1:0] tag, bit touch);
    for (int i = 0; i < live_slots(); i++) begin
      if (dir_used[i] && dir_tag[i] == tag) begin
        if (touch) begin
          use_clock    = use_clock + 64'd1;
          dir_stamp[i] = use_clock;
        end
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void drop_tag(logic [REG_BITS-1:0] tag);
    for (int i = 0; i < live_slots(); i++) begin
      if (dir_used[i] && dir_tag[i] == tag) dir_used[i] = 1'b0;
    end
  endfunction

  // Hit slot if there is one, else the first empty slot, else the oldest stamp. Stamps
  // are unique once written, and the strict compare keeps the lowest index on a tie.
  function automatic int claim_slot(logic [REG_BITS-1:0] tag, output bit was_hit);
    int pick;
    pick    = find_slot(tag, 1'b1);
    was_hit = (pick >= 0);
    if (was_hit) return pick;
    pick = -1;
    for (int i = 0; i < live_slots(); i++) begin
      if (!dir_used[i]) begin
        pick = i;
        break;
      end
      if (pick < 0 || dir_stamp[i] < dir_stamp[pick]) pick = i;
    end
    if (dir_used[pick]) eviction_count++;
    dir_used[pick]  = 1'b1;
    dir_tag[pick]   = tag;
    use_clock       = use_clock + 64'd1;
    dir_stamp[pick] = use_clock;
    return pick;
  endfunction

  // Works out the result word of one operation and moves the shadow directory on.
  function automatic dir_result_t resolve_operation(logic [OP_W-1:0] op,
                                                    logic [REG_BITS-1:0] dst,
                                                    logic [REG_BITS-1:0] src);
    dir_result_t res;
    bit          bad_index;
    bit          was_hit;
    int          slot;
    was_hit = 1'b0;
    slot    = -1;
    case (op)
      OP_WRITE:                bad_index = (dst >= reg_count);
      OP_PREPARE, OP_MULTIPLY: bad_index = (dst >= reg_count) || (src >= reg_count);
      default:                 bad_index = 1'b0;
    endcase
    if (!bad_index) begin
      case (op)
        OP_WRITE: begin
          drop_tag(dst);
        end
        OP_PREPARE: begin
          if (dst != src) drop_tag(dst);
          if (live_slots() != 0) slot = claim_slot(dst, was_hit);
        end
        OP_MULTIPLY: begin
          // The lookup comes first, so a multiply onto its own source still hits.
          slot    = find_slot(src, 1'b1);
          was_hit = (slot >= 0);
          drop_tag(dst);
        end
        default: begin
        end
      endcase
    end
    res.hit        = was_hit;
    res.slot_valid = (slot >= 0);
    res.slot_index = (slot >= 0) ? SLOT_OUT_W'(slot) : '0;
    res.status     = bad_index;
    return res;
  endfunction

  // Register writes as the directory sees them: a new active count empties every slot
  // but keeps the clock and the stamps.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_REG_COUNT: begin
        reg_count = value[RCNT_W-1:0];
      end
      CFG_ACTIVE_SLOTS: begin
        active_slots = value[ACT_W-1:0];
        foreach (dir_used[i]) dir_used[i] = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic stim_row_t row(logic [OP_W-1:0] op, logic [REG_BITS-1:0] dst,
                                    logic [REG_BITS-1:0] src, bit typed,
                                    dir_result_t res);
    stim_row_t r;
    r.op    = op;
    r.dst   = dst;
    r.src   = src;
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  // Register indices lean towards a pool only a little larger than the slot count, so
  // that hits, reuse and evictions are common. The rest are full-width values and the
  // two sides of the index limit.
  function automatic logic [REG_BITS-1:0] pick_register();
    int pool;
    int r;
    pool = live_slots() + 3;
    if (pool > reg_count) pool = int'(reg_count);
    r = $urandom_range(99);
    if (r < 72) return REG_BITS'($urandom_range(pool - 1));
    if (r < 86) return REG_BITS'($urandom);
    if (r < 93) return REG_BITS'(reg_count - 1'b1);
    return REG_BITS'(reg_count);
  endfunction

  // ---------------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------
  // Receiver: the output stall follows a pattern of its own, switching at random
  // between never stalling, stalling at random and long stall runs.
  // ---------------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int run_left;
    bit stall_on;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    stall_on  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(99) < 35);
        end
        default: begin
          if (run_left == 0) begin
            stall_on = !stall_on;
            run_left = stall_on ? $urandom_range(3, 30) : $urandom_range(1, 10);
          end
          run_left--;
          out_stall <= stall_on;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Result checker. Every word taken from the output is compared with the oldest
  // pending result; a word with nothing pending is a failure in its own right.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hit, out_slot_valid, out_slot_index, out_status};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result word at %0t ns: hit=%0b slot_valid=%0b slot=%0d status=%0b",
                   $time, got.hit, got.slot_valid, got.slot_index, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.slot_valid !== want.slot_valid ||
            got.slot_index !== want.slot_index || got.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"Mismatch at %0t ns: expected hit=%0b slot_valid=%0b slot=%0d ",
                      "status=%0b, got hit=%0b slot_valid=%0b slot=%0d status=%0b"},
                     $time, want.hit, want.slot_valid, want.slot_index, want.status,
                     got.hit, got.slot_valid, got.slot_index, got.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Watchdog: the run is abandoned once the idle count, cleared whenever a word moves
  // on any channel or reset is held, reaches IDLE_LIMIT.
  // ---------------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog expired: no word moved for %0d cycles", IDLE_LIMIT);
    $display("lru_prepared_operand_directory_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Stimulus tasks.
  // ---------------------------------------------------------------------------------

  // Presents one word and holds it until it is taken; the shadow directory is advanced
  // at the edge of acceptance.
  task automatic drive_word(input logic [OP_W-1:0] op, input logic [REG_BITS-1:0] dst,
                            input logic [REG_BITS-1:0] src, input bit typed,
                            input dir_result_t typed_res);
    dir_result_t predicted;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_dst_reg   <= dst;
    in_src_reg   <= src;
    do @(posedge clk); while (in_stall);
    predicted = resolve_operation(op, dst, src);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    case (op)
      OP_WRITE:    write_count++;
      OP_PREPARE:  prepare_count++;
      OP_MULTIPLY: multiply_count++;
      default:     unused_count++;
    endcase
    if (predicted.hit) hit_count++;
    if (predicted.status) range_error_count++;
  endtask

  // Bursts of back-to-back words separated by random gaps; some bursts are long, so
  // that stretches without any sender idling occur too.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 15);
    end
  endtask

  // The valid line drops for at least one edge, so the next word never lands in the
  // same time step as the drop.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Registers are written only once the block has gone quiet.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, value);
  endtask

  // Random operations under the current setting. Multiplies frequently name the last
  // prepared register, and prepares and multiplies sometimes name one register twice.
  // Halfway through, the sender waits for every pending result to come back.
  task automatic run_random_words(input int count);
    logic [OP_W-1:0]     op;
    logic [REG_BITS-1:0] dst;
    logic [REG_BITS-1:0] src;
    int                  r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 5)       op = OP_UNUSED;
      else if (r < 30) op = OP_WRITE;
      else if (r < 68) op = OP_PREPARE;
      else             op = OP_MULTIPLY;
      dst = pick_register();
      src = pick_register();
      r   = $urandom_range(99);
      if (op == OP_PREPARE && r < 25) src = dst;
      if (op == OP_MULTIPLY) begin
        if (r < 40)      src = last_prepared;
        else if (r < 55) dst = src;
      end
      if (op == OP_PREPARE) last_prepared = dst;
      if (k == count / 2) hold_until_drained();
      drive_word(op, dst, src, 1'b0, RES_EMPTY);
      pace_sender();
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------
  initial begin
    fail_count        = 0;
    words_sent        = 0;
    write_count       = 0;
    prepare_count     = 0;
    multiply_count    = 0;
    unused_count      = 0;
    hit_count         = 0;
    range_error_count = 0;
    eviction_count    = 0;
    setting_count     = 1;
    burst_left        = 0;
    last_prepared     = '0;

    // Shadow state after reset: sixteen registers, two slots, everything empty.
    reg_count    = 17'd16;
    active_slots = 6'd2;
    use_clock    = '0;
    foreach (dir_used[i]) begin
      dir_used[i]  = 1'b0;
      dir_tag[i]   = '0;
      dir_stamp[i] = '0;
    end

    // Directed words under the reset setting: first allocation, hits, an eviction,
    // a multiply onto its own source, a miss, both ends of the index range and beyond,
    // and the unused operation code with every index bit set.
    directed_rows = '{
      row(OP_WRITE,    16'd0,     16'd0,     1'b1, RES_EMPTY),
      row(OP_PREPARE,  16'd3,     16'd5,     1'b1, RES_FIRST),
      row(OP_PREPARE,  16'd3,     16'd3,     1'b0, RES_EMPTY),
      row(OP_PREPARE,  16'd7,     16'd3,     1'b0, RES_EMPTY),
      row(OP_MULTIPLY, 16'd0,     16'd3,     1'b0, RES_EMPTY),
      row(OP_PREPARE,  16'd9,     16'd2,     1'b0, RES_EMPTY),
      row(OP_MULTIPLY, 16'd9,     16'd9,     1'b0, RES_EMPTY),
      row(OP_MULTIPLY, 16'd1,     16'd9,     1'b0, RES_EMPTY),
      row(OP_WRITE,    16'd15,    16'd0,     1'b1, RES_EMPTY),
      row(OP_WRITE,    16'd3,     16'd0,     1'b1, RES_EMPTY),
      row(OP_PREPARE,  16'd15,    16'd0,     1'b0, RES_EMPTY),
      row(OP_WRITE,    16'd16,    16'd0,     1'b1, RES_RANGE),
      row(OP_WRITE,    16'd65535, 16'd65535, 1'b1, RES_RANGE),
      row(OP_PREPARE,  16'd0,     16'd16,    1'b1, RES_RANGE),
      row(OP_PREPARE,  16'd65535, 16'd0,     1'b1, RES_RANGE),
      row(OP_MULTIPLY, 16'd16,    16'd0,     1'b1, RES_RANGE),
      row(OP_MULTIPLY, 16'd0,     16'd65535, 1'b1, RES_RANGE),
      row(OP_UNUSED,   16'd65535, 16'd65535, 1'b1, RES_EMPTY),
      row(OP_UNUSED,   16'd0,     16'd0,     1'b1, RES_EMPTY),
      row(OP_WRITE,    16'd0,     16'd65535, 1'b1, RES_EMPTY),
      row(OP_PREPARE,  16'd15,    16'd15,    1'b0, RES_EMPTY),
      row(OP_MULTIPLY, 16'd15,    16'd15,    1'b0, RES_EMPTY)
    };

    // Every input is known from the first instant.
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_WRITE;
    in_dst_reg   <= '0;
    in_src_reg   <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_REG_COUNT;
    cfg_data     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].op, directed_rows[i].dst, directed_rows[i].src,
                 directed_rows[i].typed, directed_rows[i].res);
      pace_sender();
    end
    run_random_words(PHASE_WORDS);

    // The remaining settings cover the full index range, a single register and a single
    // slot, no slots at all, a count above the slot total, and a few in between.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_register(CFG_REG_COUNT, CFG_DATA_W'(phase_reg_count[p]));
      write_register(CFG_ACTIVE_SLOTS, CFG_DATA_W'(phase_active[p]));
      setting_count++;
      run_random_words(PHASE_WORDS);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;

    $display("Directory run: %0d words over %0d settings (%0d writes, %0d prepares, %0d multiplies, %0d unused).",
             words_sent, setting_count, write_count, prepare_count, multiply_count,
             unused_count);
    $display("Slot hits %0d, evictions %0d, index range errors %0d, mismatches %0d.",
             hit_count, eviction_count, range_error_count, fail_count);
    if (fail_count == 0) begin
      $display("lru_prepared_operand_directory_core verification clean");
    end else begin
      $display("lru_prepared_operand_directory_core verification failed");
    end
    $finish;
  end

endmodule
